@@ rtl/jwfq_pkg.sv @@
// jwfq_pkg: shared types, codes and constants of the job watchdog and fault quarantine unit
// used by the channel interfaces, the front end, the back end and the top level
package jwfq_pkg;

   // field widths
   localparam int CMD_WIDTH       = 3;
   localparam int CLIENT_WIDTH    = 32;
   localparam int FAULT_WIDTH     = 16;
   localparam int TICK_WIDTH      = 32;
   localparam int RESET_CNT_WIDTH = 32;

   // client table depth default
   localparam int TABLE_DEPTH_DEFAULT = 16;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_JOB_TIMEOUT      = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUARANTINE_LEVEL = 1'd1;
   localparam logic [TICK_WIDTH-1:0]  TIMEOUT_RESET   = 32'd30;
   localparam logic [FAULT_WIDTH-1:0] THRESHOLD_RESET = 16'd3;

   // command codes on the request channel
   localparam logic [CMD_WIDTH-1:0] CMD_TICK     = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_START    = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_COMPLETE = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_FAIL     = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_CLEAR    = 3'd4;
   localparam logic [CMD_WIDTH-1:0] CMD_QUERY    = 3'd5;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = 1;
   localparam int QCNT_WIDTH  = 2;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_START,
      OP_COMPLETE,
      OP_FAIL,
      OP_CLEAR,
      OP_QUERY
   } op_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_FAULT,
      ACT_CLEAR
   } act_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]    command;
      logic [CLIENT_WIDTH-1:0] client_id;
      logic                    health_available;
      logic                    health_needs_reset;
   } req_payload_type;

   typedef struct packed {
      logic                       is_quarantined;
      logic [FAULT_WIDTH-1:0]     client_faults;
      logic                       job_running;
      logic                       job_overdue;
      logic                       timeout_fired;
      logic                       newly_quarantined;
      logic                       fault_dropped;
      logic                       reset_edge;
      logic [RESET_CNT_WIDTH-1:0] reset_total;
   } rsp_payload_type;

   // classified item held in the queue
   typedef struct packed {
      op_type                  op;
      logic [CLIENT_WIDTH-1:0] client_id;
      logic                    health_available;
      logic                    health_needs_reset;
   } item_type;

   // one client table entry
   typedef struct packed {
      logic [CLIENT_WIDTH-1:0] client;
      logic [FAULT_WIDTH-1:0]  faults;
      logic                    quarantine;
   } entry_type;

endpackage

@@ rtl/jwfq_channels.sv @@
// jwfq_req_if and jwfq_rsp_if: valid/ready channels of the request and response sides
// depends on jwfq_pkg for the payload types
interface jwfq_req_if;
   import jwfq_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface jwfq_rsp_if;
   import jwfq_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/job_watchdog_fault_quarantine_unit.sv @@
//  channel   dir  handshake         carries
//  req_chan  in   valid/ready       command, client_id, health_available, health_needs_reset
//  rsp_chan  out  valid/ready       client status, job status, fault and reset-edge flags
//  csr_*     in   write enable      job timeout (index 0), quarantine level (index 1)
//
//  an item with no fault or clear to apply walks the client entries in use once; a fault or a
//  clear walks them to find the entry, updates or adds it, then walks again to report on the
//  named client; each walk reads one table entry per cycle and stops at the first match
//  reset is synchronous and active high; the client table needs no clearing pass
//  a two-beat queue lets requests in while the back end works or its result waits
//
// job_watchdog_fault_quarantine_unit: top level with configuration registers
// depends on jwfq_pkg, jwfq_channels, jwfq_front and jwfq_back
module job_watchdog_fault_quarantine_unit #(
   parameter int TABLE_DEPTH = jwfq_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   jwfq_req_if.sink                              req_chan,
   jwfq_rsp_if.source                            rsp_chan,
   input  logic                                  csr_wr_en,
   input  logic [jwfq_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [jwfq_pkg::CSR_DATA_WIDTH-1:0]   csr_wr_data
);
   import jwfq_pkg::*;

   logic [TICK_WIDTH-1:0]  timeout_ff, timeout_in;
   logic [FAULT_WIDTH-1:0] threshold_ff, threshold_in;
   item_type               q_item;
   logic                   q_valid;
   logic                   q_pop;
   logic                   eng_busy;

   // configuration register writes
   always_comb begin
      timeout_in   = timeout_ff;
      threshold_in = threshold_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_JOB_TIMEOUT:      timeout_in   = TICK_WIDTH'(csr_wr_data);
            CSR_QUARANTINE_LEVEL: threshold_in = csr_wr_data[FAULT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         timeout_ff   <= timeout_in;
         threshold_ff <= threshold_in;
      end
   end

   // front end: accept and classify
   jwfq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop)
   );

   // back end: watchdog, table walk, response
   jwfq_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_item        (q_item),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .cfg_timeout   (timeout_ff),
      .cfg_threshold (threshold_ff),
      .rsp_chan      (rsp_chan),
      .eng_busy      (eng_busy)
   );

   // back end only takes an item the queue holds
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("item popped from an empty queue");

   // a beat accepted into an empty queue is offered to the back end next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !q_valid) |=> q_valid)
      else $error("accepted beat did not reach the queue head");

   // a popped item starts the sequencer
   assert property (@(posedge clock) disable iff (reset) q_pop |=> eng_busy)
      else $error("popped item did not start work");

   // a result is only raised by a working sequencer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(eng_busy))
      else $error("response raised without an item in work");

endmodule

@@ rtl/jwfq_front.sv @@
// jwfq_front: accepts request beats, classifies the command and queues the item
// depends on jwfq_pkg and jwfq_req_if
module jwfq_front (
   input  logic               clock,
   input  logic               reset,
   jwfq_req_if.sink           req_chan,
   output jwfq_pkg::item_type q_item,
   output logic               q_valid,
   input  logic               q_pop
);
   import jwfq_pkg::*;

   item_type               q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;
   item_type               push_item;
   logic                   push;
   logic                   pop;

   // command classification
   always_comb begin
      push_item.client_id          = req_chan.payload.client_id;
      push_item.health_available   = req_chan.payload.health_available;
      push_item.health_needs_reset = req_chan.payload.health_needs_reset;
      unique case (req_chan.payload.command)
         CMD_TICK:     push_item.op = OP_TICK;
         CMD_START:    push_item.op = OP_START;
         CMD_COMPLETE: push_item.op = OP_COMPLETE;
         CMD_FAIL:     push_item.op = OP_FAIL;
         CMD_CLEAR:    push_item.op = OP_CLEAR;
         default:      push_item.op = OP_QUERY;
      endcase
   end

   // queue handshake
   assign req_chan.ready = (count_ff < QCNT_WIDTH'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != '0);
   assign pop            = q_pop && q_valid;
   assign q_item         = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = QPTR_WIDTH'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = QPTR_WIDTH'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = QCNT_WIDTH'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_WIDTH'(count_ff - 1'b1);
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/jwfq_back.sv @@
// jwfq_back: runs queued items: job watchdog, health edge counter, serial client table walk
// depends on jwfq_pkg and jwfq_rsp_if; holds the client table memory and the response register
module jwfq_back #(
   parameter int TABLE_DEPTH = jwfq_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  jwfq_pkg::item_type                 q_item,
   input  logic                               q_valid,
   output logic                               q_pop,
   input  logic [jwfq_pkg::TICK_WIDTH-1:0]    cfg_timeout,
   input  logic [jwfq_pkg::FAULT_WIDTH-1:0]   cfg_threshold,
   jwfq_rsp_if.source                         rsp_chan,
   output logic                               eng_busy
);
   import jwfq_pkg::*;

   localparam int IDX_WIDTH = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(TABLE_DEPTH + 1);

   // client table
   entry_type                  table_mem_ff [TABLE_DEPTH];
   entry_type                  rd_data_ff;
   logic                       rd_en;
   logic                       wr_en;
   logic [IDX_WIDTH-1:0]       wr_addr;
   entry_type                  wr_data;

   // control state
   state_type                  state_ff, state_in;
   act_type                    act_ff, act_in;
   logic                       report_ff, report_in;
   logic [CNT_WIDTH-1:0]       rd_idx_ff, rd_idx_in;
   logic                       cmp_vld_ff, cmp_vld_in;
   logic                       hit_ff, hit_in;
   logic [CNT_WIDTH-1:0]       used_ff, used_in;
   logic                       job_active_ff, job_active_in;
   logic [CLIENT_WIDTH-1:0]    job_client_ff, job_client_in;
   logic [TICK_WIDTH-1:0]      job_elapsed_ff, job_elapsed_in;
   logic                       reset_latched_ff, reset_latched_in;
   logic [RESET_CNT_WIDTH-1:0] reset_count_ff, reset_count_in;
   logic                       fired_ff, fired_in;
   logic                       newq_ff, newq_in;
   logic                       dropped_ff, dropped_in;
   logic                       edge_ff, edge_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [CLIENT_WIDTH-1:0]    item_client_ff, item_client_in;
   logic [CLIENT_WIDTH-1:0]    key_ff, key_in;
   logic [IDX_WIDTH-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [IDX_WIDTH-1:0]       hit_idx_ff, hit_idx_in;
   entry_type                  hit_entry_ff, hit_entry_in;
   rsp_payload_type            rsp_data_ff, rsp_data_in;

   // helpers
   logic                       issue;
   logic                       match;
   logic [TICK_WIDTH-1:0]      elapsed_sat;
   logic [FAULT_WIDTH-1:0]     faults_sat;
   logic                       table_full;

   assign issue       = (rd_idx_ff < used_ff);
   assign match       = cmp_vld_ff && (rd_data_ff.client == key_ff);
   assign elapsed_sat = (job_elapsed_ff == '1) ? job_elapsed_ff
                                               : TICK_WIDTH'(job_elapsed_ff + 1'b1);
   assign faults_sat  = (hit_entry_ff.faults == '1) ? hit_entry_ff.faults
                                                    : FAULT_WIDTH'(hit_entry_ff.faults + 1'b1);
   assign table_full  = (used_ff >= CNT_WIDTH'(TABLE_DEPTH));

   // sequencer: next state and datapath
   always_comb begin
      state_in         = state_ff;
      act_in           = act_ff;
      report_in        = report_ff;
      rd_idx_in        = rd_idx_ff;
      cmp_vld_in       = cmp_vld_ff;
      hit_in           = hit_ff;
      used_in          = used_ff;
      job_active_in    = job_active_ff;
      job_client_in    = job_client_ff;
      job_elapsed_in   = job_elapsed_ff;
      reset_latched_in = reset_latched_ff;
      reset_count_in   = reset_count_ff;
      fired_in         = fired_ff;
      newq_in          = newq_ff;
      dropped_in       = dropped_ff;
      edge_in          = edge_ff;
      item_client_in   = item_client_ff;
      key_in           = key_ff;
      cmp_idx_in       = cmp_idx_ff;
      hit_idx_in       = hit_idx_ff;
      hit_entry_in     = hit_entry_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_valid_in     = rsp_valid_ff;
      q_pop            = 1'b0;
      rd_en            = 1'b0;
      wr_en            = 1'b0;
      wr_addr          = hit_idx_ff;
      wr_data          = hit_entry_ff;

      // response taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop          = 1'b1;
               item_client_in = q_item.client_id;
               key_in         = q_item.client_id;
               act_in         = ACT_NONE;
               fired_in       = 1'b0;
               newq_in        = 1'b0;
               dropped_in     = 1'b0;
               edge_in        = 1'b0;
               rd_idx_in      = '0;
               cmp_vld_in     = 1'b0;
               unique case (q_item.op)
                  OP_TICK: begin
                     // age the job, fault its client on timeout
                     if (job_active_ff) begin
                        job_elapsed_in = elapsed_sat;
                        if (elapsed_sat > cfg_timeout) begin
                           act_in        = ACT_FAULT;
                           key_in        = job_client_ff;
                           job_active_in = 1'b0;
                           fired_in      = 1'b1;
                        end
                     end
                     // reset-needed edge detect
                     if (q_item.health_available && q_item.health_needs_reset) begin
                        reset_latched_in = 1'b1;
                        if (!reset_latched_ff) begin
                           edge_in = 1'b1;
                           if (reset_count_ff != '1) begin
                              reset_count_in = RESET_CNT_WIDTH'(reset_count_ff + 1'b1);
                           end
                        end
                     end else begin
                        reset_latched_in = 1'b0;
                     end
                  end
                  OP_START: begin
                     job_client_in  = q_item.client_id;
                     job_active_in  = 1'b1;
                     job_elapsed_in = '0;
                  end
                  OP_COMPLETE: begin
                     job_active_in = 1'b0;
                  end
                  OP_FAIL: begin
                     job_active_in = 1'b0;
                     act_in        = ACT_FAULT;
                  end
                  OP_CLEAR: begin
                     act_in = ACT_CLEAR;
                  end
                  default: begin
                  end
               endcase
               report_in = (act_in == ACT_NONE);
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one table read per cycle, compared in the following cycle
            if (match || !issue) begin
               hit_in       = match;
               hit_idx_in   = cmp_idx_ff;
               hit_entry_in = rd_data_ff;
               state_in     = report_ff ? ST_RESULT : ST_UPDATE;
            end else begin
               rd_en      = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[IDX_WIDTH-1:0];
               rd_idx_in  = CNT_WIDTH'(rd_idx_ff + 1'b1);
            end
         end
         ST_UPDATE: begin
            unique case (act_ff)
               ACT_FAULT: begin
                  if (hit_ff) begin
                     wr_en              = 1'b1;
                     wr_addr            = hit_idx_ff;
                     wr_data.client     = hit_entry_ff.client;
                     wr_data.faults     = faults_sat;
                     wr_data.quarantine = hit_entry_ff.quarantine
                                          || (faults_sat >= cfg_threshold);
                     newq_in = !hit_entry_ff.quarantine && (faults_sat >= cfg_threshold);
                  end else if (table_full) begin
                     dropped_in = 1'b1;
                  end else begin
                     // new entry with its first fault
                     wr_en              = 1'b1;
                     wr_addr            = used_ff[IDX_WIDTH-1:0];
                     wr_data.client     = key_ff;
                     wr_data.faults     = FAULT_WIDTH'(1);
                     wr_data.quarantine = (FAULT_WIDTH'(1) >= cfg_threshold);
                     newq_in            = (FAULT_WIDTH'(1) >= cfg_threshold);
                     used_in            = CNT_WIDTH'(used_ff + 1'b1);
                  end
               end
               ACT_CLEAR: begin
                  if (hit_ff) begin
                     wr_en              = 1'b1;
                     wr_addr            = hit_idx_ff;
                     wr_data.client     = hit_entry_ff.client;
                     wr_data.faults     = '0;
                     wr_data.quarantine = 1'b0;
                  end
               end
               default: begin
               end
            endcase
            // second walk reports on the named client
            key_in     = item_client_ff;
            report_in  = 1'b1;
            rd_idx_in  = '0;
            cmp_vld_in = 1'b0;
            state_in   = ST_SCAN;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_data_in.is_quarantined    = hit_ff && hit_entry_ff.quarantine;
               rsp_data_in.client_faults     = hit_ff ? hit_entry_ff.faults : '0;
               rsp_data_in.job_running       = job_active_ff;
               rsp_data_in.job_overdue       = job_active_ff && (job_elapsed_ff > cfg_timeout);
               rsp_data_in.timeout_fired     = fired_ff;
               rsp_data_in.newly_quarantined = newq_ff;
               rsp_data_in.fault_dropped     = dropped_ff;
               rsp_data_in.reset_edge        = edge_ff;
               rsp_data_in.reset_total       = reset_count_ff;
               rsp_valid_in                  = 1'b1;
               state_in                      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff           <= ACT_NONE;
         report_ff        <= 1'b0;
         rd_idx_ff        <= '0;
         cmp_vld_ff       <= 1'b0;
         hit_ff           <= 1'b0;
         used_ff          <= '0;
         job_active_ff    <= 1'b0;
         job_client_ff    <= '0;
         job_elapsed_ff   <= '0;
         reset_latched_ff <= 1'b0;
         reset_count_ff   <= '0;
         fired_ff         <= 1'b0;
         newq_ff          <= 1'b0;
         dropped_ff       <= 1'b0;
         edge_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         act_ff           <= act_in;
         report_ff        <= report_in;
         rd_idx_ff        <= rd_idx_in;
         cmp_vld_ff       <= cmp_vld_in;
         hit_ff           <= hit_in;
         used_ff          <= used_in;
         job_active_ff    <= job_active_in;
         job_client_ff    <= job_client_in;
         job_elapsed_ff   <= job_elapsed_in;
         reset_latched_ff <= reset_latched_in;
         reset_count_ff   <= reset_count_in;
         fired_ff         <= fired_in;
         newq_ff          <= newq_in;
         dropped_ff       <= dropped_in;
         edge_ff          <= edge_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_client_ff <= item_client_in;
      key_ff         <= key_in;
      cmp_idx_ff     <= cmp_idx_in;
      hit_idx_ff     <= hit_idx_in;
      hit_entry_ff   <= hit_entry_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // client table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem_ff[rd_idx_ff[IDX_WIDTH-1:0]];
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;
   assign eng_busy         = (state_ff != ST_IDLE);

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for job_watchdog_fault_quarantine_unit, with its own status predictor
// depends on jwfq_pkg, the jwfq_req_if / jwfq_rsp_if channels and the unit's rtl
module tb_top;
   import jwfq_pkg::*;

   localparam int          CLK_PERIOD       = 4;
   localparam int          RESET_CYCLES     = 5;
   localparam int          SLOTS            = TABLE_DEPTH_DEFAULT;
   localparam int          POOL_SIZE        = 20;
   localparam int          PHASES           = 6;
   localparam int          BEATS_PER_PHASE  = 100;
   localparam int          IDLE_PERCENT     = 35;
   localparam int          HOLD_AT          = 180;
   localparam int          HOLD_CYCLES      = 400;
   localparam int          STEADY_RSP_FIRST = 400;
   localparam int          STEADY_RSP_LAST  = 520;
   localparam int          STALL_LIMIT      = 3000;
   localparam int          SETTLE_CYCLES    = 60;
   // commands past query, treated as a query by the unit
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_7 = 3'd7;

   // status predictor and in-order store of expected status beats
   class quarantine_scoreboard;
      logic [TICK_WIDTH-1:0]      timeout_ticks;
      logic [FAULT_WIDTH-1:0]     threshold;
      bit                         slot_valid[SLOTS];
      logic [CLIENT_WIDTH-1:0]    slot_client[SLOTS];
      logic [FAULT_WIDTH-1:0]     slot_faults[SLOTS];
      bit                         slot_quar[SLOTS];
      int                         slots_used;
      bit                         job_on;
      logic [CLIENT_WIDTH-1:0]    job_owner;
      logic [TICK_WIDTH-1:0]      job_ticks;
      bit                         health_latch;
      logic [RESET_CNT_WIDTH-1:0] health_edges;
      rsp_payload_type            status_due[$];
      int unsigned                errors;

      function new();
         timeout_ticks = TIMEOUT_RESET;
         threshold     = THRESHOLD_RESET;
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         slots_used   = 0;
         job_on       = 1'b0;
         job_owner    = '0;
         job_ticks    = '0;
         health_latch = 1'b0;
         health_edges = '0;
         errors       = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                 logic [CSR_DATA_WIDTH-1:0] value);
         if (index == CSR_JOB_TIMEOUT)
            timeout_ticks = value;
         else
            threshold = value[FAULT_WIDTH-1:0];
      endfunction

      function int pending();
         return status_due.size();
      endfunction

      function int find_slot(logic [CLIENT_WIDTH-1:0] id);
         for (int i = 0; i < slots_used; i++) begin
            if (slot_valid[i] && slot_client[i] == id)
               return i;
         end
         return -1;
      endfunction

      // charge one fault, allocating an entry on first fault
      function void charge_fault(logic [CLIENT_WIDTH-1:0] id, inout bit newq, inout bit dropped);
         int slot;
         slot = find_slot(id);
         if (slot < 0) begin
            if (slots_used >= SLOTS) begin
               dropped = 1'b1;
               return;
            end
            slot = slots_used;
            slots_used++;
            slot_valid[slot]  = 1'b1;
            slot_client[slot] = id;
            slot_faults[slot] = '0;
            slot_quar[slot]   = 1'b0;
         end
         if (slot_faults[slot] != '1)
            slot_faults[slot]++;
         if (slot_faults[slot] >= threshold && !slot_quar[slot]) begin
            slot_quar[slot] = 1'b1;
            newq = 1'b1;
         end
      endfunction

      function rsp_payload_type predict_status(req_payload_type ev);
         rsp_payload_type st;
         bit              newq;
         bit              dropped;
         bit              fired;
         bit              rose;
         int              slot;
         newq    = 1'b0;
         dropped = 1'b0;
         fired   = 1'b0;
         rose    = 1'b0;
         case (ev.command)
            CMD_TICK: begin
               if (job_on) begin
                  if (job_ticks != '1)
                     job_ticks++;
                  if (job_ticks > timeout_ticks) begin
                     charge_fault(job_owner, newq, dropped);
                     job_on = 1'b0;
                     fired  = 1'b1;
                  end
               end
               // health latch, counting rising edges only
               if (ev.health_available && ev.health_needs_reset) begin
                  if (!health_latch) begin
                     health_latch = 1'b1;
                     if (health_edges != '1)
                        health_edges++;
                     rose = 1'b1;
                  end
               end else begin
                  health_latch = 1'b0;
               end
            end
            CMD_START: begin
               job_owner = ev.client_id;
               job_on    = 1'b1;
               job_ticks = '0;
            end
            CMD_COMPLETE: begin
               job_on = 1'b0;
            end
            CMD_FAIL: begin
               job_on = 1'b0;
               charge_fault(ev.client_id, newq, dropped);
            end
            CMD_CLEAR: begin
               slot = find_slot(ev.client_id);
               if (slot >= 0) begin
                  slot_quar[slot]   = 1'b0;
                  slot_faults[slot] = '0;
               end
            end
            default: begin
            end
         endcase
         slot = find_slot(ev.client_id);
         st                   = '0;
         st.is_quarantined    = (slot >= 0) ? slot_quar[slot] : 1'b0;
         st.client_faults     = (slot >= 0) ? slot_faults[slot] : '0;
         st.job_running       = job_on;
         st.job_overdue       = job_on && (job_ticks > timeout_ticks);
         st.timeout_fired     = fired;
         st.newly_quarantined = newq;
         st.fault_dropped     = dropped;
         st.reset_edge        = rose;
         st.reset_total       = health_edges;
         return st;
      endfunction

      function void note_event(req_payload_type ev);
         status_due.push_back(predict_status(ev));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_status(rsp_payload_type got);
         rsp_payload_type want;
         if (status_due.size() == 0) begin
            $error("status beat with nothing expected: %0h", got);
            errors++;
            return;
         end
         want = status_due.pop_front();
         compare_field("is_quarantined", 32'(want.is_quarantined), 32'(got.is_quarantined));
         compare_field("client_faults", 32'(want.client_faults), 32'(got.client_faults));
         compare_field("job_running", 32'(want.job_running), 32'(got.job_running));
         compare_field("job_overdue", 32'(want.job_overdue), 32'(got.job_overdue));
         compare_field("timeout_fired", 32'(want.timeout_fired), 32'(got.timeout_fired));
         compare_field("newly_quarantined", 32'(want.newly_quarantined),
                       32'(got.newly_quarantined));
         compare_field("fault_dropped", 32'(want.fault_dropped), 32'(got.fault_dropped));
         compare_field("reset_edge", 32'(want.reset_edge), 32'(got.reset_edge));
         compare_field("reset_total", 32'(want.reset_total), 32'(got.reset_total));
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wr_data;

   jwfq_req_if req_if();
   jwfq_rsp_if rsp_if();

   job_watchdog_fault_quarantine_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   quarantine_scoreboard    sb = new();
   logic [CLIENT_WIDTH-1:0] client_pool[POOL_SIZE];
   bit                      steady_send;
   int unsigned             events_sent;
   int unsigned             stall_cycles;

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // watchdog on cycles with no beat moving on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one request beat, with random idle cycles ahead of it unless steady sending is on
   task automatic send_event(logic [CMD_WIDTH-1:0] cmd, logic [CLIENT_WIDTH-1:0] id,
                             bit avail, bit needs);
      req_payload_type ev;
      ev.command            = cmd;
      ev.client_id          = id;
      ev.health_available   = avail;
      ev.health_needs_reset = needs;
      if (!steady_send && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < IDLE_PERCENT);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= ev;
      do @(posedge clock); while (!req_if.ready);
      sb.note_event(ev);
      events_sent++;
   endtask

   task automatic wait_all_status();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] index, logic [CSR_DATA_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_register(index, value);
      @(posedge clock);
   endtask

   function automatic logic [CLIENT_WIDTH-1:0] pick_client();
      if ($urandom_range(0, 99) < 8)
         return $urandom();
      return client_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // random single bit for the health flags
   function automatic bit coin();
      return 1'($urandom_range(0, 1));
   endfunction

   // most ticks per job: enough to cross a small timeout, a handful otherwise
   function automatic int unsigned tick_span();
      if (sb.timeout_ticks <= 40)
         return sb.timeout_ticks + 3;
      return 8;
   endfunction

   // mostly job lifetimes with random content, plus stray clears, queries, faults and noise
   task automatic run_random(int unsigned count);
      int unsigned            goal;
      int unsigned            pick;
      int unsigned            ticks;
      logic [CLIENT_WIDTH-1:0] who;
      goal = events_sent + count;
      while (events_sent < goal) begin
         pick = $urandom_range(0, 9);
         who  = pick_client();
         if (pick < 6) begin
            send_event(CMD_START, who, coin(), coin());
            ticks = $urandom_range(0, tick_span());
            repeat (ticks) begin
               if ($urandom_range(0, 99) < 15)
                  send_event(CMD_QUERY, pick_client(), coin(), coin());
               else
                  send_event(CMD_TICK, pick_client(), coin(), coin());
            end
            case ($urandom_range(0, 2))
               0: send_event(CMD_COMPLETE, who, coin(), coin());
               1: send_event(CMD_FAIL, who, coin(), coin());
               default: begin
               end
            endcase
         end else if (pick == 6) begin
            send_event(CMD_CLEAR, who, coin(), coin());
         end else if (pick == 7) begin
            send_event(CMD_QUERY, who, coin(), coin());
         end else if (pick == 8) begin
            send_event(CMD_FAIL, who, coin(), coin());
         end else begin
            send_event(CMD_WIDTH'($urandom_range(0, 7)), $urandom(), coin(), coin());
         end
      end
   endtask

   // response side: random ready, one long hold-off, one stretch always ready
   initial begin : rsp_side
      int unsigned seen;
      bit          held;
      seen = 0;
      held = 1'b0;
      rsp_if.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (seen == HOLD_AT && !held) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (seen >= STEADY_RSP_FIRST && seen < STEADY_RSP_LAST)
            rsp_if.ready <= 1'b1;
         else
            rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_status(rsp_if.payload);
            seen++;
         end
      end
   end

   initial begin : req_side
      logic [TICK_WIDTH-1:0]  phase_timeout;
      logic [FAULT_WIDTH-1:0] phase_threshold;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_JOB_TIMEOUT;
      csr_wr_data    = '0;
      steady_send    = 1'b0;
      events_sent    = 0;
      client_pool[0] = '0;
      client_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) client_pool[i] = $urandom();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: health edges, quarantine at default threshold, clears, job corner cases
      send_event(CMD_QUERY, 32'h0, 1'b1, 1'b1);
      send_event(CMD_TICK, 32'h0, 1'b1, 1'b1);
      send_event(CMD_TICK, 32'h0, 1'b1, 1'b1);
      send_event(CMD_TICK, 32'h0, 1'b0, 1'b1);
      send_event(CMD_TICK, 32'h0, 1'b1, 1'b0);
      send_event(CMD_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_event(CMD_FAIL, 32'h0, 1'b0, 1'b0);
      send_event(CMD_FAIL, 32'h0, 1'b0, 1'b0);
      send_event(CMD_FAIL, 32'h0, 1'b0, 1'b0);
      send_event(CMD_FAIL, 32'h0, 1'b1, 1'b1);
      send_event(CMD_FAIL, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_event(CMD_CLEAR, 32'h0, 1'b0, 1'b0);
      send_event(CMD_CLEAR, 32'h1234_5678, 1'b0, 1'b0);
      send_event(CMD_COMPLETE, 32'h0, 1'b0, 1'b0);
      send_event(CMD_START, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_event(CMD_START, 32'h0, 1'b0, 1'b0);
      send_event(CMD_TICK, 32'h0, 1'b0, 1'b0);
      send_event(CMD_COMPLETE, 32'h0, 1'b0, 1'b0);
      send_event(CMD_SPARE_6, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_event(CMD_SPARE_7, 32'h0, 1'b1, 1'b1);
      send_event(CMD_START, 32'hA5A5_A5A5, 1'b0, 1'b0);
      send_event(CMD_FAIL, 32'hA5A5_A5A5, 1'b0, 1'b0);
      // zero timeout fires on the first tick, threshold of one quarantines at once
      wait_all_status();
      csr_write(CSR_JOB_TIMEOUT, 32'd0);
      csr_write(CSR_QUARANTINE_LEVEL, 32'd1);
      send_event(CMD_START, 32'h5A5A_5A5A, 1'b0, 1'b0);
      send_event(CMD_TICK, 32'h5A5A_5A5A, 1'b0, 1'b0);
      // largest settings: no timeout, no quarantine
      wait_all_status();
      csr_write(CSR_JOB_TIMEOUT, 32'hFFFF_FFFF);
      csr_write(CSR_QUARANTINE_LEVEL, 32'h0000_FFFF);
      send_event(CMD_START, 32'h0000_0005, 1'b0, 1'b0);
      send_event(CMD_TICK, 32'h0000_0005, 1'b0, 1'b0);
      send_event(CMD_FAIL, 32'h0000_0005, 1'b0, 1'b0);

      // random phases, each under its own register setting
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               phase_timeout   = TIMEOUT_RESET;
               phase_threshold = THRESHOLD_RESET;
            end
            1: begin
               phase_timeout   = 32'd2;
               phase_threshold = 16'd1;
            end
            2: begin
               phase_timeout   = 32'd0;
               phase_threshold = 16'd0;
            end
            3: begin
               phase_timeout   = 32'hFFFF_FFFF;
               phase_threshold = 16'hFFFF;
            end
            default: begin
               phase_timeout   = $urandom_range(0, 6);
               phase_threshold = FAULT_WIDTH'($urandom_range(1, 5));
            end
         endcase
         wait_all_status();
         csr_write(CSR_JOB_TIMEOUT, phase_timeout);
         csr_write(CSR_QUARANTINE_LEVEL, {16'd0, phase_threshold});
         steady_send = (p == 4);
         run_random(BEATS_PER_PHASE);
      end

      // drain, then let any stray beat show up
      wait_all_status();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d status beats never arrived", sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
